// ----- design/xsp_pkg.sv -----
// Package for the xyz to spherical pan/tilt unit: widths, transaction types,
// register indexes, arithmetic constants and small helper functions.
// No dependencies; every other file of the block imports it.
package xsp_pkg;

  // Field widths
  localparam int COORD_W   = 16;
  localparam int OFS_W     = 16;
  localparam int HDG_W     = 15;
  localparam int ANG_W     = 15;
  localparam int RNG_W     = 17;
  localparam int MAG_W     = COORD_W + 1;   // magnitude of a coordinate difference
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_HEADING  = 2'd2
  } cfg_reg_e;

  // Angle units
  localparam int ANG_F       = 6;
  localparam int ACC_F       = 16;
  localparam int UNIT_SH     = ACC_F - ANG_F;
  localparam int UNIT_RND    = 1 << (UNIT_SH - 1);
  localparam int FULL_CIRCLE = 360 << ANG_F;
  localparam int CIRC_W      = ANG_W + 1;
  localparam int PHI_W       = 26;
  localparam int HALF_TURN   = 180 << ACC_F;

  // Operand normalisation: largest operand brought to bit NORM_TOP
  localparam int NORM_TOP = 29;
  localparam int NORM_W   = NORM_TOP + 1;
  localparam int NSH_W    = 5;
  localparam int SQ_W     = 2 * MAG_W;      // one squared magnitude
  localparam int SUM_W    = SQ_W;           // sum of three squares fits here
  localparam int HSQ_W    = 2 * NORM_W;
  localparam int HSUM_W   = HSQ_W + 1;

  // CORDIC vectoring
  localparam int CO_STEPS = 20;
  localparam int CO_IN_W  = NORM_W + 1;
  localparam int CO_W     = CO_IN_W + 4;
  localparam int Z_W      = 25;
  localparam int ACC_ANG_W = 23;
  localparam int ANG_MAX  = 90 << ACC_F;

  // Square root (restoring, one result bit per stage)
  localparam int SQ_OUT_W = 31;
  localparam int SQ_IN_W  = 2 * SQ_OUT_W;
  localparam int SQ_REM_W = SQ_OUT_W + 2;

  // Range: floor((root + 120) / 240) as ((root + 120) >> 4) / 15 by reciprocal
  localparam int RNG_ROOT_W = 25;
  localparam int RNG_BIAS   = 120;
  localparam int RNG_PRE_SH = 4;
  localparam int RNG_V_W    = RNG_ROOT_W + 1 - RNG_PRE_SH;
  localparam int RNG_MUL_W  = 23;
  localparam int RNG_MUL    = 4473925;
  localparam int RNG_MUL_SH = 26;
  localparam int RNG_P_W    = RNG_V_W + RNG_MUL_W;
  localparam int RNG_Q_W    = RNG_P_W - RNG_MUL_SH;
  localparam int RANGE_MAX  = (1 << RNG_W) - 1;

  // Pipeline alignment (cycles)
  localparam int TZ_DLY     = SQ_OUT_W;
  localparam int PAN_DLY    = 33;
  localparam int RNG_DLY    = 20;
  localparam int FLG_DLY    = 54;
  localparam int PIPE_DEPTH = 57;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      in_last;
  } pt_in_t;

  typedef struct packed {
    logic [ANG_W-1:0] pan_angle;
    logic [ANG_W-1:0] tilt_angle;
    logic [RNG_W-1:0] range_value;
    logic             out_last;
  } pt_out_t;

  // Classified point: magnitudes and signs
  typedef struct packed {
    logic [MAG_W-1:0] ax;
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] az;
    logic             sx;
    logic             sy;
    logic             sz;
    logic             last;
  } mag_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // atan(2^-i) in degrees, 16 fraction bits
  function automatic logic [ACC_ANG_W-1:0] atan_val(input int i);
    logic [ACC_ANG_W-1:0] v;
    case (i)
      0:  v = 23'd2949120;
      1:  v = 23'd1740967;
      2:  v = 23'd919879;
      3:  v = 23'd466945;
      4:  v = 23'd234379;
      5:  v = 23'd117304;
      6:  v = 23'd58666;
      7:  v = 23'd29335;
      8:  v = 23'd14668;
      9:  v = 23'd7334;
      10: v = 23'd3667;
      11: v = 23'd1833;
      12: v = 23'd917;
      13: v = 23'd458;
      14: v = 23'd229;
      15: v = 23'd115;
      16: v = 23'd57;
      17: v = 23'd29;
      18: v = 23'd14;
      19: v = 23'd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Left shift that brings the top set bit of m to NORM_TOP (0 for zero)
  function automatic logic [NSH_W-1:0] norm_shift(input logic [MAG_W-1:0] m);
    logic [NSH_W-1:0] s;
    s = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (m[i]) s = NSH_W'(NORM_TOP - i);
    end
    return s;
  endfunction

  // Accumulator angle to output units, rounded half up, reduced to the circle
  function automatic logic [CIRC_W-1:0] to_units(input logic [PHI_W-1:0] a);
    logic [PHI_W-1:0] t;
    t = (a + PHI_W'(UNIT_RND)) >> UNIT_SH;
    if (t >= PHI_W'(FULL_CIRCLE)) t = t - PHI_W'(FULL_CIRCLE);
    return CIRC_W'(t);
  endfunction

endpackage

// ----- design/xsp_fifo.sv -----
// Short transaction queue between the front and back parts.
// Depends on xsp_pkg (mag_item_t, fifo_stat_t, depth constants).
module xsp_fifo import xsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  mag_item_t  push_data_i,
  input  logic       pop_i,
  output mag_item_t  head_o,
  output fifo_stat_t stat_o
);

  mag_item_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_q, rd_q;
  logic [FIFO_AW:0]     cnt_q;

  assign stat_o.full  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ----- design/xsp_front.sv -----
// Front part: takes point transactions, subtracts the horizontal offset
// and classifies into magnitudes and signs. Depends on xsp_pkg.
module xsp_front import xsp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  pt_in_t                  in_data_i,
  input  logic signed [OFS_W-1:0] offset_x_i,
  input  logic signed [OFS_W-1:0] offset_y_i,
  input  fifo_stat_t              fifo_stat_i,
  output logic                    push_o,
  output mag_item_t               item_o
);

  logic signed [MAG_W-1:0] dx, dy, dz;
  mag_item_t               item_d, item_q;
  logic                    vld_q;
  logic                    load;

  // offset subtraction and magnitudes
  assign dx = MAG_W'(in_data_i.point_x) - MAG_W'(offset_x_i);
  assign dy = MAG_W'(in_data_i.point_y) - MAG_W'(offset_y_i);
  assign dz = MAG_W'(in_data_i.point_z);

  always_comb begin
    item_d.ax   = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    item_d.ay   = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    item_d.az   = dz[MAG_W-1] ? MAG_W'(-dz) : MAG_W'(dz);
    item_d.sx   = dx[MAG_W-1];
    item_d.sy   = dy[MAG_W-1];
    item_d.sz   = dz[MAG_W-1];
    item_d.last = in_data_i.in_last;
  end

  // holding register: refills whenever the queue can take its content
  assign load       = !vld_q || !fifo_stat_i.full;
  assign in_stall_o = vld_q && fifo_stat_i.full;
  assign push_o     = vld_q && !fifo_stat_i.full;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) item_q <= item_d;
  end

endmodule

// ----- design/xsp_isqrt.sv -----
// Pipelined restoring integer square root, one result bit per stage.
// Depends on xsp_pkg (SQ_* widths).
module xsp_isqrt import xsp_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [SQ_IN_W-1:0]  rad_i,
  output logic [SQ_OUT_W-1:0] root_o
);

  logic [SQ_REM_W-1:0] rem_q  [SQ_OUT_W];
  logic [SQ_OUT_W-1:0] root_q [SQ_OUT_W];
  logic [SQ_IN_W-1:0]  rad_q  [SQ_OUT_W];

  for (genvar k = 0; k < SQ_OUT_W; k++) begin : g_stage
    logic [SQ_REM_W-1:0] rem_in;
    logic [SQ_OUT_W-1:0] root_in;
    logic [SQ_IN_W-1:0]  rad_in;
    logic [SQ_REM_W+1:0] r2, trial;
    logic                ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // bring down two bits, try root*4+1
    assign r2    = {rem_in, rad_in[SQ_IN_W-1 -: 2]};
    assign trial = (SQ_REM_W+2)'({root_in, 2'b01});
    assign ge    = (r2 >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? SQ_REM_W'(r2 - trial) : SQ_REM_W'(r2);
        root_q[k] <= {root_in[SQ_OUT_W-2:0], ge};
        rad_q[k]  <= {rad_in[SQ_IN_W-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[SQ_OUT_W-1];

endmodule

// ----- design/xsp_cordic.sv -----
// Pipelined CORDIC vectoring: angle of a non-negative (x, y) in [0, 90]
// degrees with 16 fraction bits, one rotation per stage. Depends on xsp_pkg.
module xsp_cordic import xsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [CO_IN_W-1:0]   x_i,
  input  logic [CO_IN_W-1:0]   y_i,
  output logic [ACC_ANG_W-1:0] ang_o
);

  logic signed [CO_W-1:0] cx_q [CO_STEPS];
  logic signed [CO_W-1:0] cy_q [CO_STEPS];
  logic signed [Z_W-1:0]  z_q  [CO_STEPS];
  logic signed [Z_W-1:0]  zf;

  for (genvar i = 0; i < CO_STEPS; i++) begin : g_stage
    logic signed [CO_W-1:0] cx_in, cy_in, ncy;
    logic signed [Z_W-1:0]  z_in, t;
    logic                   pos;

    if (i == 0) begin : g_first
      assign cx_in = $signed(CO_W'(x_i));
      assign cy_in = $signed(CO_W'(y_i));
      assign z_in  = '0;
    end else begin : g_next
      assign cx_in = cx_q[i-1];
      assign cy_in = cy_q[i-1];
      assign z_in  = z_q[i-1];
    end

    assign ncy = -cy_in;
    assign pos = (cy_in > 0);
    assign t   = $signed(Z_W'(atan_val(i)));

    // rotate towards the x axis
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (pos) begin
          cx_q[i] <= cx_in + (cy_in >>> i);
          cy_q[i] <= cy_in - (cx_in >>> i);
          z_q[i]  <= z_in + t;
        end else begin
          cx_q[i] <= cx_in + (ncy >>> i);
          cy_q[i] <= cy_in + (cx_in >>> i);
          z_q[i]  <= z_in - t;
        end
      end
    end
  end

  // clamp to [0, 90] degrees
  assign zf = z_q[CO_STEPS-1];

  always_comb begin
    if (zf < 0)                            ang_o = '0;
    else if (zf > $signed(Z_W'(ANG_MAX)))  ang_o = ACC_ANG_W'(ANG_MAX);
    else                                   ang_o = ACC_ANG_W'(zf);
  end

endmodule

// ----- design/xsp_back.sv -----
// Back part: normalisation, square roots, CORDIC angles, range division and
// final quadrant/heading correction in one stallable pipeline.
// Depends on xsp_pkg, xsp_isqrt and xsp_cordic.
module xsp_back import xsp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mag_item_t        head_i,
  input  fifo_stat_t       fifo_stat_i,
  output logic             pop_o,
  input  logic [HDG_W-1:0] heading_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pt_out_t          out_data_o
);

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_q;

  // stage A
  mag_item_t        a_item_q;
  logic [NSH_W-1:0] a_lp_q, a_lt_q;
  logic [SQ_W-1:0]  a_sqx_q, a_sqy_q, a_sqz_q;
  logic [MAG_W-1:0] pmax, tmax;

  // stage B
  logic [NORM_W-1:0] b_nx_q, b_ny_q, b_tx_q, b_ty_q, b_tz_q;
  logic [SUM_W-1:0]  b_s_q;

  // stages C and D
  logic [HSQ_W-1:0]  c_hx2_q, c_hy2_q;
  logic [NORM_W-1:0] c_tz_q, d_tz_q;
  logic [HSUM_W-1:0] d_hsum_q;

  // square roots and angles
  logic [SQ_OUT_W-1:0]  rng_root, h_root;
  logic [ACC_ANG_W-1:0] pan_ang, tilt_ang;

  // delay lines
  logic [NORM_W-1:0]    tzd_q  [TZ_DLY];
  logic [ACC_ANG_W-1:0] pand_q [PAN_DLY];
  logic [RNG_W-1:0]     rngd_q [RNG_DLY];
  logic [3:0]           fld_q  [FLG_DLY];

  // range division
  logic [RNG_ROOT_W:0] r_biased;
  logic [RNG_P_W-1:0]  r1_prod_q;
  logic [RNG_Q_W-1:0]  r_quot;
  logic [RNG_W-1:0]    r2_rng_q;

  // final stages
  logic [PHI_W-1:0]  phi;
  logic [CIRC_W-1:0] p1_pan_q, p1_tilt_q;
  logic [RNG_W-1:0]  p1_rng_q;
  logic [3:0]        p1_fl_q, fl_end;
  logic [CIRC_W-1:0] hmod, tilt_fin;
  logic [CIRC_W:0]   pan_sum;
  pt_out_t           o_q;

  // whole pipeline advances unless the output transaction is held
  assign en          = !(vld_q[PIPE_DEPTH-1] && out_stall_i);
  assign pop_o       = en && !fifo_stat_i.empty;
  assign out_valid_o = vld_q[PIPE_DEPTH-1];
  assign out_data_o  = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], pop_o};
    end
  end

  // A: shift amounts for the pan pair and the tilt triple, range squares
  assign pmax = (head_i.ax > head_i.ay) ? head_i.ax : head_i.ay;
  assign tmax = (pmax > head_i.az) ? pmax : head_i.az;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_item_q <= head_i;
      a_lp_q   <= norm_shift(pmax);
      a_lt_q   <= norm_shift(tmax);
      a_sqx_q  <= head_i.ax * head_i.ax;
      a_sqy_q  <= head_i.ay * head_i.ay;
      a_sqz_q  <= head_i.az * head_i.az;
    end
  end

  // B: normalised operands, sum of squares
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_nx_q <= NORM_W'(a_item_q.ax) << a_lp_q;
      b_ny_q <= NORM_W'(a_item_q.ay) << a_lp_q;
      b_tx_q <= NORM_W'(a_item_q.ax) << a_lt_q;
      b_ty_q <= NORM_W'(a_item_q.ay) << a_lt_q;
      b_tz_q <= NORM_W'(a_item_q.az) << a_lt_q;
      b_s_q  <= a_sqx_q + a_sqy_q + a_sqz_q;
    end
  end

  // C, D: horizontal squared magnitude for tilt
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_hx2_q  <= b_tx_q * b_tx_q;
      c_hy2_q  <= b_ty_q * b_ty_q;
      c_tz_q   <= b_tz_q;
      d_hsum_q <= HSUM_W'(c_hx2_q) + HSUM_W'(c_hy2_q);
      d_tz_q   <= c_tz_q;
    end
  end

  xsp_cordic u_pan_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (CO_IN_W'(b_nx_q)),
    .y_i   (CO_IN_W'(b_ny_q)),
    .ang_o (pan_ang)
  );

  xsp_isqrt u_rng_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (SQ_IN_W'({b_s_q, 16'b0})),
    .root_o (rng_root)
  );

  xsp_isqrt u_hor_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (SQ_IN_W'(d_hsum_q)),
    .root_o (h_root)
  );

  xsp_cordic u_tilt_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (CO_IN_W'(h_root)),
    .y_i   (CO_IN_W'(tzd_q[TZ_DLY-1])),
    .ang_o (tilt_ang)
  );

  // range: bias, reciprocal multiply, saturate
  assign r_biased = (RNG_ROOT_W+1)'(rng_root[RNG_ROOT_W-1:0]) + (RNG_ROOT_W+1)'(RNG_BIAS);
  assign r_quot   = RNG_Q_W'(r1_prod_q >> RNG_MUL_SH);

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_prod_q <= RNG_P_W'(RNG_V_W'(r_biased >> RNG_PRE_SH)) * RNG_P_W'(RNG_MUL);
      r2_rng_q  <= (r_quot > RNG_Q_W'(RANGE_MAX)) ? RNG_W'(RANGE_MAX) : RNG_W'(r_quot);
    end
  end

  // alignment delay lines
  always_ff @(posedge clk_i) begin
    if (en) begin
      tzd_q[0]  <= d_tz_q;
      pand_q[0] <= pan_ang;
      rngd_q[0] <= r2_rng_q;
      fld_q[0]  <= {a_item_q.sx, a_item_q.sy, a_item_q.sz, a_item_q.last};
      for (int i = 1; i < TZ_DLY; i++)  tzd_q[i]  <= tzd_q[i-1];
      for (int i = 1; i < PAN_DLY; i++) pand_q[i] <= pand_q[i-1];
      for (int i = 1; i < RNG_DLY; i++) rngd_q[i] <= rngd_q[i-1];
      for (int i = 1; i < FLG_DLY; i++) fld_q[i]  <= fld_q[i-1];
    end
  end

  // P1: pan quadrant from the signs of dx and dy, conversion to units
  assign fl_end = fld_q[FLG_DLY-1];

  always_comb begin
    case ({fl_end[3], fl_end[2]})
      2'b00:   phi = PHI_W'(pand_q[PAN_DLY-1]);
      2'b10:   phi = PHI_W'(HALF_TURN) - PHI_W'(pand_q[PAN_DLY-1]);
      2'b11:   phi = PHI_W'(HALF_TURN) + PHI_W'(pand_q[PAN_DLY-1]);
      default: phi = PHI_W'(2 * HALF_TURN) - PHI_W'(pand_q[PAN_DLY-1]);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_pan_q  <= to_units(phi);
      p1_tilt_q <= to_units(PHI_W'(tilt_ang));
      p1_rng_q  <= rngd_q[RNG_DLY-1];
      p1_fl_q   <= fl_end;
    end
  end

  // P2: heading correction, tilt below the horizon, output register
  assign hmod    = (CIRC_W'(heading_i) >= CIRC_W'(FULL_CIRCLE)) ?
                   CIRC_W'(heading_i) - CIRC_W'(FULL_CIRCLE) : CIRC_W'(heading_i);
  assign pan_sum = (CIRC_W+1)'(p1_pan_q) + (CIRC_W+1)'(FULL_CIRCLE) - (CIRC_W+1)'(hmod);

  always_comb begin
    if (p1_fl_q[1] && (p1_tilt_q != '0)) tilt_fin = CIRC_W'(FULL_CIRCLE) - p1_tilt_q;
    else                                 tilt_fin = p1_tilt_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_q.pan_angle   <= (pan_sum >= (CIRC_W+1)'(FULL_CIRCLE)) ?
                         ANG_W'(pan_sum - (CIRC_W+1)'(FULL_CIRCLE)) : ANG_W'(pan_sum);
      o_q.tilt_angle  <= ANG_W'(tilt_fin);
      o_q.range_value <= p1_rng_q;
      o_q.out_last    <= p1_fl_q[0];
    end
  end

endmodule

// ----- design/xyz_to_spherical_pan_tilt_unit.sv -----
// Top level of the xyz to spherical pan/tilt unit: configuration registers,
// front part, queue and back part. Depends on xsp_pkg and all xsp_* modules.
//
//   port group   direction  handshake              payload
//   in           in         in_valid_i/in_stall_o   pt_in_t  (point_x/y/z, in_last)
//   out          out        out_valid_o/out_stall_i pt_out_t (pan, tilt, range, last)
//   cfg          in         cfg_we_i                cfg_idx_i, cfg_data_i
//
// One point per cycle sustained while the output is not held; each point passes
// from the front register through the queue into the 57-stage back pipeline,
// whose depth is set by the 31-stage square root in series with the
// 20-stage CORDIC on the tilt path.
// Reset clears the valid bits, the queue pointers and the configuration registers;
// data registers are not reset.
// A held output stalls the whole back pipeline; the four-entry queue and the
// front register absorb transactions before the input stall rises.
module xyz_to_spherical_pan_tilt_unit import xsp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pt_in_t               in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pt_out_t              out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic signed [OFS_W-1:0] offset_x_q, offset_y_q;
  logic [HDG_W-1:0]        heading_q;
  logic                    push, pop;
  mag_item_t               push_item, head_item;
  fifo_stat_t              fifo_stat;

  // configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= '0;
      offset_y_q <= '0;
      heading_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OFFSET_X: offset_x_q <= $signed(OFS_W'(cfg_data_i));
        REG_OFFSET_Y: offset_y_q <= $signed(OFS_W'(cfg_data_i));
        REG_HEADING:  heading_q  <= HDG_W'(cfg_data_i);
        default:      ;
      endcase
    end
  end

  xsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .offset_x_i  (offset_x_q),
    .offset_y_i  (offset_y_q),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .item_o      (push_item)
  );

  xsp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .pop_i       (pop),
    .head_o      (head_item),
    .stat_o      (fifo_stat)
  );

  xsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_item),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .heading_i   (heading_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- sim/xyz_to_spherical_pan_tilt_unit_tb.sv -----
// Self-checking testbench for xyz_to_spherical_pan_tilt_unit: a queue-fed
// driver, a monitor and a bit-exact predictor. Depends on xsp_pkg and the RTL.
module xyz_to_spherical_pan_tilt_unit_tb;
  import xsp_pkg::*;

  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int DRAIN_CYCLES    = 80;
  localparam int RANDOM_PER_SET  = 380;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall_o;
  pt_in_t               in_data = '0;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  pt_out_t              out_data_o;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Predictor copy of the registers
  logic signed [OFS_W-1:0] ofs_x = '0;
  logic signed [OFS_W-1:0] ofs_y = '0;
  logic [HDG_W-1:0]        hdg   = '0;

  pt_in_t  point_q[$];
  pt_out_t spherical_q[$];
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      mismatches = 0;
  int      points_sent = 0;
  int      results_seen = 0;
  int      quiet_cycles = 0;
  bit      hold_req = 0;
  bit      hold_done = 0;
  int      hold_left = 0;

  xyz_to_spherical_pan_tilt_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk_i = ~clk_i;

  // atan(2^-i) in degrees with 16 fraction bits
  function automatic longint atan_step(input int i);
    longint tab [20] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                         29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57,
                         29, 14, 7};
    return tab[i];
  endfunction

  // Net shift that brings the largest operand into [2^29, 2^30)
  function automatic int scale_shift(input longint unsigned m);
    int s;
    s = 0;
    if (m == 0) return 0;
    while (m < (64'd1 << 29)) begin m = m << 1; s++; end
    while (m >= (64'd1 << 30)) begin m = m >> 1; s--; end
    return s;
  endfunction

  function automatic longint unsigned apply_shift(input longint unsigned v, input int s);
    return (s >= 0) ? (v << s) : (v >> (-s));
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Vectoring angle of non-negative (x, y), clamped to [0, 90] degrees
  function automatic longint vector_angle(input longint x, input longint y);
    longint cx, cy, nx, z;
    cx = x; cy = y; z = 0;
    for (int i = 0; i < 20; i++) begin
      if (cy > 0) begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        z  = z + atan_step(i);
      end else begin
        nx = cx + ((-cy) >>> i);
        cy = cy + (cx >>> i);
        z  = z - atan_step(i);
      end
      cx = nx;
    end
    if (z < 0) z = 0;
    if (z > (longint'(90) << 16)) z = longint'(90) << 16;
    return z;
  endfunction

  function automatic longint unsigned angle_units(input longint unsigned a);
    return ((a + 512) >> 10) % FULL_CIRCLE;
  endfunction

  function automatic pt_out_t spherical_of(input pt_in_t p);
    pt_out_t r;
    longint dx, dy, dz, phi;
    longint unsigned ax, ay, az, px, py, tx, ty, tz, hm, pan, tilt, rng, half;
    int s;
    half = 64'd180 << 16;
    dx = longint'(p.point_x) - longint'(ofs_x);
    dy = longint'(p.point_y) - longint'(ofs_y);
    dz = longint'(p.point_z);
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    az = (dz < 0) ? -dz : dz;
    // pan from the horizontal vector
    s = scale_shift((ax > ay) ? ax : ay);
    px = apply_shift(ax, s);
    py = apply_shift(ay, s);
    phi = vector_angle(px, py);
    if (dx >= 0 && dy >= 0)      phi = phi;
    else if (dx < 0 && dy >= 0)  phi = half - phi;
    else if (dx < 0)             phi = half + phi;
    else                         phi = 2 * half - phi;
    pan = angle_units(phi);
    pan = (pan + FULL_CIRCLE - (hdg % FULL_CIRCLE)) % FULL_CIRCLE;
    // tilt against the horizontal magnitude, operands scaled together
    s = scale_shift((ax > ay) ? ((ax > az) ? ax : az) : ((ay > az) ? ay : az));
    tx = apply_shift(ax, s);
    ty = apply_shift(ay, s);
    tz = apply_shift(az, s);
    hm = int_sqrt(tx * tx + ty * ty);
    tilt = angle_units(vector_angle(hm, tz));
    if (dz < 0) tilt = (FULL_CIRCLE - tilt) % FULL_CIRCLE;
    rng = (int_sqrt((ax * ax + ay * ay + az * az) << 16) + 120) / 240;
    if (rng > RANGE_MAX) rng = RANGE_MAX;
    r.pan_angle   = pan[ANG_W-1:0];
    r.tilt_angle  = tilt[ANG_W-1:0];
    r.range_value = rng[RNG_W-1:0];
    r.out_last    = p.in_last;
    return r;
  endfunction

  // Driver: predicts on acceptance, offers the next pending point
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall_o) begin
        spherical_q = {spherical_q, spherical_of(in_data)};
        points_sent++;
      end
      if (!in_valid || !in_stall_o) begin
        if (point_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data  <= point_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall, one long hold-off on request, field compare
  always @(posedge clk_i or negedge rst_ni) begin
    pt_out_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (spherical_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction %p", out_data_o);
        end else begin
          want = spherical_q.pop_front();
          if (out_data_o.pan_angle !== want.pan_angle ||
              out_data_o.tilt_angle !== want.tilt_angle ||
              out_data_o.range_value !== want.range_value ||
              out_data_o.out_last !== want.out_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", want, out_data_o);
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic add_point(input int x, input int y, input int z, input bit last);
    pt_in_t p;
    p.point_x = x[COORD_W-1:0];
    p.point_y = y[COORD_W-1:0];
    p.point_z = z[COORD_W-1:0];
    p.in_last = last;
    point_q = {point_q, p};
  endtask

  task automatic wait_idle();
    while (point_q.size() > 0 || in_valid || spherical_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive edges
  task automatic set_regs(input int ox, input int oy, input int hd);
    @(posedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= REG_OFFSET_X; cfg_data <= ox[CFG_W-1:0];
    ofs_x = ox[OFS_W-1:0];
    @(posedge clk_i);
    cfg_idx <= REG_OFFSET_Y; cfg_data <= oy[CFG_W-1:0];
    ofs_y = oy[OFS_W-1:0];
    @(posedge clk_i);
    cfg_idx <= REG_HEADING; cfg_data <= hd[CFG_W-1:0];
    hdg = hd[HDG_W-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Random points: near the offset, on axes, or anywhere
  task automatic add_random(input int n);
    int kind, x, y, z;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(9);
      x = $urandom_range(65535) - 32768;
      y = $urandom_range(65535) - 32768;
      z = $urandom_range(65535) - 32768;
      if (kind < 2) begin
        x = int'(ofs_x) + $urandom_range(6) - 3;
        y = int'(ofs_y) + $urandom_range(6) - 3;
        z = $urandom_range(6) - 3;
        if (x > 32767) x = 32767;
        if (x < -32768) x = -32768;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
      end else if (kind < 4) begin
        case ($urandom_range(2))
          0: x = int'(ofs_x);
          1: y = int'(ofs_y);
          default: z = 0;
        endcase
      end
      add_point(x, y, z, $urandom_range(1));
    end
  endtask

  initial begin
    int ox[5] = '{0, 32767, -32768, 0, 1234};
    int oy[5] = '{0, -32768, 32767, 0, -77};
    int hd[5] = '{0, 23039, 32767, 0, 11520};
    int sidle[4] = '{0, 57, 0, 19};
    int sstall[4] = '{0, 0, 57, 19};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 3) begin
        ox[3] = $urandom_range(65535) - 32768;
        oy[3] = $urandom_range(65535) - 32768;
        hd[3] = $urandom_range(23039);
      end
      set_regs(ox[ph], oy[ph], hd[ph]);
      send_idle_pct = sidle[ph % 4];
      stall_pct = sstall[ph % 4];
      if (ph == 0) begin
        // zero vector, axes, quadrants, extremes
        add_point(0, 0, 0, 0);
        add_point(0, 0, 0, 1);
        add_point(100, 0, 0, 0);
        add_point(0, 100, 0, 0);
        add_point(-100, 0, 0, 1);
        add_point(0, -100, 0, 0);
        add_point(0, 0, 100, 0);
        add_point(0, 0, -100, 1);
        add_point(5, 5, 5, 0);
        add_point(-5, 5, -5, 0);
        add_point(-5, -5, 5, 1);
        add_point(5, -5, -5, 0);
        add_point(32767, 32767, 32767, 0);
        add_point(-32768, -32768, -32768, 1);
        add_point(32767, -32768, 0, 0);
        add_point(-32768, 32767, -1, 0);
        add_point(1, 0, -1, 1);
        add_point(-1, -1, 0, 0);
        add_point(1, 1, 32767, 0);
        add_point(-1, 0, -32768, 1);
        hold_req = 1;
      end
      add_random(RANDOM_PER_SET);
      wait_idle();
    end
    $display("Covered %0d points over five register settings with idle and stall mixes,",
             points_sent);
    $display("including a long output hold-off; %0d results checked.", results_seen);
    if (mismatches == 0 && spherical_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
